@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the favc RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FAVC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("favc: same-cycle check failed");

// next-cycle implication
`define FAVC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("favc: next-cycle check failed");

`endif

@@ rtl/core/favc_pkg.sv @@
// ---------------------------------------------------------------------------
// favc_pkg
// Types and constants of the length-prefixed to start-code converter.
// ---------------------------------------------------------------------------
package favc_pkg;

    localparam int unsigned QUEUE_DEPTH = 5;

    localparam logic [2:0] HEADER_BYTES = 3'd5;
    localparam logic [2:0] LENGTH_BYTES = 3'd4;
    localparam logic [2:0] OFFSET_START = 3'd2;
    localparam logic [31:0] SIGN_FIX = 32'hff80_0000;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    // one queued command: start code, payload byte (maybe with trailing status), or status
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        ulast;
        logic [1:0]  stat;
        logic [31:0] decode;
        logic [31:0] present;
    } cmd_t;

endpackage

@@ rtl/core/favc_pkt_if.sv @@
// ---------------------------------------------------------------------------
// favc_pkt_if
// Packet byte channel: one packet byte with its framing and timestamp.
// ---------------------------------------------------------------------------
interface favc_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        packet_first;
    logic        packet_last;
    logic        config_packet;
    logic [31:0] packet_time;

    modport source (
        output valid, data_byte, packet_first, packet_last, config_packet, packet_time,
        input  ready
    );
    modport sink (
        input  valid, data_byte, packet_first, packet_last, config_packet, packet_time,
        output ready
    );
endinterface

@@ rtl/core/favc_nal_if.sv @@
// ---------------------------------------------------------------------------
// favc_nal_if
// Annex B byte channel: one output word with unit framing, times and status.
// ---------------------------------------------------------------------------
interface favc_nal_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        unit_first;
    logic        unit_last;
    logic [31:0] decode_time;
    logic [31:0] present_time;
    logic [1:0]  status;
    logic        run_last;

    modport source (
        output valid, out_byte, unit_first, unit_last, decode_time, present_time,
               status, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, unit_first, unit_last, decode_time, present_time,
               status, run_last,
        output ready
    );
endinterface

@@ rtl/core/favc_front.sv @@
// ---------------------------------------------------------------------------
// favc_front
// Packet parser: header, composition offset, unit lengths; issues at most one command
// per accepted word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module favc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    favc_pkt_if.sink             pkt,
    output logic                 push_valid,
    input  logic                 push_ready,
    output favc_pkg::cmd_t       push_cmd
);

    favc_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [23:0] off_reg, off_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] dec_reg, dec_next;
    logic [31:0] pres_reg, pres_next;
    logic        has_cmd;
    logic [1:0]  st;
    logic        accept;

    assign pkt.ready  = push_ready;
    assign accept     = pkt.valid && push_ready;
    assign push_valid = accept && has_cmd;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        dec_next   = dec_reg;
        pres_next  = pres_reg;
        st         = favc_pkg::ST_DATA;
        has_cmd    = 1'b0;
        push_cmd   = '{kind: favc_pkg::CMD_START, data: 8'd0, ulast: 1'b0,
                       stat: favc_pkg::ST_DATA, decode: 32'd0, present: 32'd0};

        if (pkt.packet_first || (phase_reg == favc_pkg::PH_HEADER && idx_reg == 3'd0))
        begin
            phase_next = pkt.config_packet ? favc_pkg::PH_DROP : favc_pkg::PH_HEADER;
            idx_next   = 3'd0;
            off_next   = 24'd0;
            len_next   = 32'd0;
            left_next  = 32'd0;
            dec_next   = pkt.packet_time;
            pres_next  = pkt.packet_time;
        end

        unique case (phase_next)
            favc_pkg::PH_DROP:
            begin
                if (idx_next < favc_pkg::HEADER_BYTES)
                begin
                    idx_next = idx_next + 3'd1;
                end
                if (pkt.packet_last && idx_next < favc_pkg::HEADER_BYTES)
                begin
                    st = favc_pkg::ST_SHORT;
                end
            end
            favc_pkg::PH_HEADER:
            begin
                if (idx_next >= favc_pkg::OFFSET_START)
                begin
                    off_next = {off_next[15:0], pkt.data_byte};
                end
                idx_next = idx_next + 3'd1;
                if (idx_next >= favc_pkg::HEADER_BYTES)
                begin
                    // sign-extend the 24-bit offset
                    pres_next  = dec_next
                               + (({8'd0, off_next} + favc_pkg::SIGN_FIX) ^ favc_pkg::SIGN_FIX);
                    phase_next = favc_pkg::PH_LENGTH;
                    idx_next   = 3'd0;
                    len_next   = 32'd0;
                end
                else if (pkt.packet_last)
                begin
                    st = favc_pkg::ST_SHORT;
                end
            end
            favc_pkg::PH_LENGTH:
            begin
                len_next = {len_next[23:0], pkt.data_byte};
                idx_next = idx_next + 3'd1;
                if (idx_next >= favc_pkg::LENGTH_BYTES)
                begin
                    left_next      = len_next;
                    idx_next       = 3'd0;
                    has_cmd        = 1'b1;
                    push_cmd.kind  = favc_pkg::CMD_START;
                    push_cmd.ulast = (len_next == 32'd0);
                    phase_next     = (len_next == 32'd0) ? favc_pkg::PH_LENGTH
                                                         : favc_pkg::PH_PAYLOAD;
                end
                else if (pkt.packet_last)
                begin
                    st = favc_pkg::ST_TRUNC;
                end
            end
            favc_pkg::PH_PAYLOAD:
            begin
                left_next      = left_next - 32'd1;
                has_cmd        = 1'b1;
                push_cmd.kind  = favc_pkg::CMD_DATA;
                push_cmd.data  = pkt.data_byte;
                push_cmd.ulast = (left_next == 32'd0);
                if (left_next == 32'd0)
                begin
                    phase_next = favc_pkg::PH_LENGTH;
                end
                else if (pkt.packet_last)
                begin
                    st = favc_pkg::ST_TRUNC;
                end
            end
            default:
            begin
                phase_next = favc_pkg::PH_HEADER;
            end
        endcase

        if (pkt.packet_last)
        begin
            if (st != favc_pkg::ST_DATA)
            begin
                push_cmd.stat = st;
                if (!has_cmd)
                begin
                    push_cmd.kind = favc_pkg::CMD_STATUS;
                    has_cmd       = 1'b1;
                end
            end
            phase_next = favc_pkg::PH_HEADER;
            idx_next   = 3'd0;
            off_next   = 24'd0;
            len_next   = 32'd0;
            left_next  = 32'd0;
        end

        push_cmd.decode  = dec_next;
        push_cmd.present = pres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= favc_pkg::PH_HEADER;
            idx_reg   <= 3'd0;
            off_reg   <= 24'd0;
            len_reg   <= 32'd0;
            left_reg  <= 32'd0;
            dec_reg   <= 32'd0;
            pres_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            dec_reg   <= dec_next;
            pres_reg  <= pres_next;
        end
    end

    `FAVC_ASSERT_IMP(a_payload_has_bytes, clk, rst_n,
        phase_reg == favc_pkg::PH_PAYLOAD, left_reg != 32'd0)
    `FAVC_ASSERT_IMP(a_length_index, clk, rst_n,
        phase_reg == favc_pkg::PH_LENGTH, idx_reg < favc_pkg::LENGTH_BYTES)

endmodule

@@ rtl/core/favc_queue.sv @@
// ---------------------------------------------------------------------------
// favc_queue
// Short command queue between parser and expander.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module favc_queue #(
    parameter int unsigned DEPTH = favc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  favc_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output favc_pkg::cmd_t pop_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    favc_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `FAVC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))

endmodule

@@ rtl/core/favc_back.sv @@
// ---------------------------------------------------------------------------
// favc_back
// Command expander: start code, payload bytes and status words onto the
// output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module favc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  favc_pkg::cmd_t pop_cmd,
    favc_nal_if.source     nal
);

    favc_pkg::cmd_t work_reg;
    logic           busy_reg;
    logic [1:0]     step_reg, step_next;
    logic           final_step;

    always_comb
    begin
        nal.out_byte   = 8'd0;
        nal.unit_first = 1'b0;
        nal.unit_last  = 1'b0;
        nal.status     = favc_pkg::ST_DATA;
        nal.run_last   = 1'b0;
        final_step     = 1'b1;
        unique case (work_reg.kind)
            favc_pkg::CMD_START:
            begin
                nal.out_byte   = {7'd0, (step_reg == 2'd3)};
                nal.unit_first = (step_reg == 2'd0);
                nal.unit_last  = (step_reg == 2'd3) && work_reg.ulast;
                final_step     = (step_reg == 2'd3);
            end
            favc_pkg::CMD_DATA:
            begin
                if (step_reg == 2'd0)
                begin
                    nal.out_byte  = work_reg.data;
                    nal.unit_last = work_reg.ulast;
                    final_step    = (work_reg.stat == favc_pkg::ST_DATA);
                end
                else
                begin
                    nal.status = work_reg.stat;
                end
            end
            favc_pkg::CMD_STATUS:
            begin
                nal.status = work_reg.stat;
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
        nal.run_last     = final_step;
        nal.decode_time  = work_reg.decode;
        nal.present_time = work_reg.present;
    end

    assign nal.valid = busy_reg;
    assign pop_ready = !busy_reg || (nal.ready && final_step);
    assign step_next = step_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (pop_ready)
        begin
            busy_reg <= pop_valid;
            step_reg <= 2'd0;
        end
        else if (nal.ready)
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            work_reg <= pop_cmd;
        end
    end

    `FAVC_ASSERT_IMP(a_status_single, clk, rst_n,
        busy_reg && work_reg.kind == favc_pkg::CMD_STATUS, step_reg == 2'd0)
    `FAVC_ASSERT_IMP(a_data_steps, clk, rst_n,
        busy_reg && work_reg.kind == favc_pkg::CMD_DATA, step_reg <= 2'd1)

endmodule

@@ rtl/core/flv_avc_length_to_annexb_top.sv @@
// ---------------------------------------------------------------------------
// flv_avc_length_to_annexb_top
// Length-prefixed AVC video packets in, Annex B start-code units out.
//
// Usage:
//   pkt : one packet byte per word, packet_first/packet_last framing,
//         config_packet and packet_time taken on the first byte.
//   nal : one output word per start-code byte, payload byte or status word,
//         tagged with decode and presentation times; run_last closes the
//         words caused by one input byte.
//   One input byte is taken per cycle while the command queue has room.
//   The fourth length byte of a unit gives four words, a payload byte one
//   (two with a trailing status), a malformed packet end one status word.
//   First output word passes the queue memory and the expander's work
//   register; output runs at one word per cycle while the receiver is
//   ready, so sustained payload input rate is one byte per cycle.
//   QUEUE_DEPTH commands absorb start-code bursts and receiver stalls; when
//   the queue fills, pkt.ready drops until the receiver drains it.
//   Reset empties the queue and returns the parser to the header phase with
//   no packet open.
// ---------------------------------------------------------------------------
module flv_avc_length_to_annexb_top #(
    parameter int unsigned QUEUE_DEPTH = favc_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    favc_pkt_if.sink     pkt,
    favc_nal_if.source   nal
);

    logic           push_valid;
    logic           push_ready;
    favc_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    favc_pkg::cmd_t pop_cmd;

    favc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    favc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    favc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .nal       (nal)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for flv_avc_length_to_annexb_top: packets of bytes go
// in with random gaps, every Annex B word coming out is checked against a
// predicted copy of the parser, with random receiver stalls.
// ---------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        cfg;
        logic [31:0] stamp;
        logic        drain;
    } pkt_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        ufirst;
        logic        ulast;
        logic [31:0] dts;
        logic [31:0] pts;
        logic [1:0]  stat;
        logic        rlast;
    } nal_word_t;

    logic clk = 1'b0;
    logic rst_n;

    favc_pkt_if pkt_bus ();
    favc_nal_if nal_bus ();

    flv_avc_length_to_annexb_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_bus),
        .nal   (nal_bus)
    );

    always #2 clk = ~clk;

    pkt_word_t   pending[$];
    logic [7:0]  body_q[$];
    nal_word_t   annexb_expected[$];
    int          faults = 0;
    int          cycles = 0;

    // parser copy
    favc_pkg::phase_t prs_phase;
    logic [2:0]  prs_count;
    logic [23:0] cts_acc;
    logic [31:0] len_acc;
    logic [31:0] nal_left;
    logic [31:0] cur_dts;
    logic [31:0] cur_pts;

    function automatic nal_word_t nal_word(logic [7:0] b, logic uf, logic ul, logic [1:0] st);
        nal_word_t r;
        r.data   = b;
        r.ufirst = uf;
        r.ulast  = ul;
        r.dts    = cur_dts;
        r.pts    = cur_pts;
        r.stat   = st;
        r.rlast  = 1'b0;
        return r;
    endfunction

    task automatic predict_annexb(input pkt_word_t w);
        nal_word_t  run [0:4];
        int         n;
        logic [1:0] stat;
        n = 0;
        stat = favc_pkg::ST_DATA;
        if (w.first || (prs_phase == favc_pkg::PH_HEADER && prs_count == 3'd0))
        begin
            prs_phase = w.cfg ? favc_pkg::PH_DROP : favc_pkg::PH_HEADER;
            prs_count = 3'd0;
            cts_acc   = '0;
            len_acc   = '0;
            nal_left  = '0;
            cur_dts   = w.stamp;
            cur_pts   = w.stamp;
        end
        case (prs_phase)
            favc_pkg::PH_DROP:
            begin
                if (prs_count < favc_pkg::HEADER_BYTES)
                    prs_count++;
                if (w.last && prs_count < favc_pkg::HEADER_BYTES)
                    stat = favc_pkg::ST_SHORT;
            end
            favc_pkg::PH_HEADER:
            begin
                if (prs_count >= favc_pkg::OFFSET_START)
                    cts_acc = {cts_acc[15:0], w.data};
                prs_count++;
                if (prs_count >= favc_pkg::HEADER_BYTES)
                begin
                    cur_pts   = cur_dts + {{8{cts_acc[23]}}, cts_acc};
                    prs_phase = favc_pkg::PH_LENGTH;
                    prs_count = 3'd0;
                    len_acc   = '0;
                end
                else if (w.last)
                    stat = favc_pkg::ST_SHORT;
            end
            favc_pkg::PH_LENGTH:
            begin
                len_acc = {len_acc[23:0], w.data};
                prs_count++;
                if (prs_count >= favc_pkg::LENGTH_BYTES)
                begin
                    nal_left  = len_acc;
                    prs_count = 3'd0;
                    run[0] = nal_word(8'h00, 1'b1, 1'b0, favc_pkg::ST_DATA);
                    run[1] = nal_word(8'h00, 1'b0, 1'b0, favc_pkg::ST_DATA);
                    run[2] = nal_word(8'h00, 1'b0, 1'b0, favc_pkg::ST_DATA);
                    run[3] = nal_word(8'h01, 1'b0, nal_left == 32'd0, favc_pkg::ST_DATA);
                    n = 4;
                    prs_phase = (nal_left == 32'd0) ? favc_pkg::PH_LENGTH
                                                    : favc_pkg::PH_PAYLOAD;
                end
                else if (w.last)
                    stat = favc_pkg::ST_TRUNC;
            end
            favc_pkg::PH_PAYLOAD:
            begin
                nal_left--;
                run[0] = nal_word(w.data, 1'b0, nal_left == 32'd0, favc_pkg::ST_DATA);
                n = 1;
                if (nal_left == 32'd0)
                    prs_phase = favc_pkg::PH_LENGTH;
                else if (w.last)
                    stat = favc_pkg::ST_TRUNC;
            end
        endcase
        if (w.last)
        begin
            if (stat != favc_pkg::ST_DATA)
            begin
                run[n] = nal_word(8'h00, 1'b0, 1'b0, stat);
                n++;
            end
            prs_phase = favc_pkg::PH_HEADER;
            prs_count = 3'd0;
            cts_acc   = '0;
            len_acc   = '0;
            nal_left  = '0;
        end
        if (n > 0)
            run[n-1].rlast = 1'b1;
        for (int i = 0; i < n; i++)
            annexb_expected.push_back(run[i]);
    endtask

    // header, then one to three units of mostly short payload
    task automatic build_media();
        int units;
        int len;
        int pick;
        repeat (5) body_q.push_back(8'($urandom));
        units = $urandom_range(1, 3);
        repeat (units)
        begin
            pick = $urandom_range(0, 9);
            len = (pick == 0) ? 0 : (pick < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            for (int k = 3; k >= 0; k--)
                body_q.push_back(8'(len >> (8 * k)));
            repeat (len) body_q.push_back(8'($urandom));
        end
    endtask

    task automatic emit_packet(logic cfg, logic [31:0] stamp, logic with_first,
                               logic with_last, logic drain);
        pkt_word_t w;
        for (int i = 0; i < body_q.size(); i++)
        begin
            w.data  = body_q[i];
            w.first = (i == 0) && with_first;
            w.last  = (i == body_q.size() - 1) && with_last;
            w.cfg   = (i == 0) ? cfg : 1'($urandom);
            w.stamp = (i == 0) ? stamp : $urandom;
            w.drain = (i == 0) && drain;
            pending.push_back(w);
        end
        body_q.delete();
    endtask

    function automatic logic quiet_phase();
        return pending.size() < 40 || (pending.size() > 120 && pending.size() < 140);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            faults++;
        end
    endfunction

    // driver
    pkt_word_t on_bus;
    int        src_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_bus.valid         <= 1'b0;
            pkt_bus.data_byte     <= '0;
            pkt_bus.packet_first  <= 1'b0;
            pkt_bus.packet_last   <= 1'b0;
            pkt_bus.config_packet <= 1'b0;
            pkt_bus.packet_time   <= '0;
            src_gap   = 0;
            prs_phase = favc_pkg::PH_HEADER;
            prs_count = 3'd0;
            cts_acc   = '0;
            len_acc   = '0;
            nal_left  = '0;
            cur_dts   = '0;
            cur_pts   = '0;
        end
        else
        begin
            if (pkt_bus.valid && pkt_bus.ready)
                predict_annexb(on_bus);
            if (!pkt_bus.valid || pkt_bus.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    pkt_bus.valid <= 1'b0;
                end
                else if (pending.size() == 0 ||
                         (pending[0].drain && annexb_expected.size() != 0))
                    pkt_bus.valid <= 1'b0;
                else if (!quiet_phase() && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 6);
                    pkt_bus.valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending.pop_front();
                    pkt_bus.valid         <= 1'b1;
                    pkt_bus.data_byte     <= on_bus.data;
                    pkt_bus.packet_first  <= on_bus.first;
                    pkt_bus.packet_last   <= on_bus.last;
                    pkt_bus.config_packet <= on_bus.cfg;
                    pkt_bus.packet_time   <= on_bus.stamp;
                end
            end
        end
    end

    // monitor
    nal_word_t want;
    int        sink_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nal_bus.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (nal_bus.valid && nal_bus.ready)
            begin
                if (annexb_expected.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h", $time,
                             nal_bus.out_byte);
                    faults++;
                end
                else
                begin
                    want = annexb_expected.pop_front();
                    check_field("out_byte", 32'(want.data), 32'(nal_bus.out_byte));
                    check_field("unit_first", 32'(want.ufirst), 32'(nal_bus.unit_first));
                    check_field("unit_last", 32'(want.ulast), 32'(nal_bus.unit_last));
                    check_field("decode_time", want.dts, nal_bus.decode_time);
                    check_field("present_time", want.pts, nal_bus.present_time);
                    check_field("status", 32'(want.stat), 32'(nal_bus.status));
                    check_field("run_last", 32'(want.rlast), 32'(nal_bus.run_last));
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap--;
                nal_bus.ready <= 1'b0;
            end
            else if (!quiet_phase() && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 6);
                nal_bus.ready <= 1'b0;
            end
            else
                nal_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int idx;
        int kind;
        int cut;
        pkt_bus.valid         = 1'b0;
        pkt_bus.data_byte     = '0;
        pkt_bus.packet_first  = 1'b0;
        pkt_bus.packet_last   = 1'b0;
        pkt_bus.config_packet = 1'b0;
        pkt_bus.packet_time   = '0;
        nal_bus.ready         = 1'b0;
        rst_n = 1'b0;

        // max positive offset wrapping the top timestamp, zero length unit, one byte unit
        body_q = '{8'hff, 8'h00, 8'h7f, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
        emit_packet(1'b0, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
        // most negative offset, huge length cut short
        body_q = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5a};
        emit_packet(1'b0, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        // short config packet
        body_q = '{8'h67, 8'h42};
        emit_packet(1'b1, 32'h1234_5678, 1'b1, 1'b1, 1'b0);

        idx = 0;
        while (pending.size() < 215)
        begin
            kind = (idx < 8) ? 7 - idx : $urandom_range(0, 15);
            case (kind)
                1:
                begin
                    repeat ($urandom_range(5, 12)) body_q.push_back(8'($urandom));
                    emit_packet(1'b1, $urandom, 1'b1, 1'b1, 1'b0);
                end
                2:
                begin
                    repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom));
                    emit_packet(1'($urandom), $urandom, 1'b1, 1'b1, 1'b0);
                end
                3:
                begin
                    build_media();
                    cut = $urandom_range(6, body_q.size() - 1);
                    while (body_q.size() > cut)
                        void'(body_q.pop_back());
                    emit_packet(1'b0, $urandom, 1'b1, 1'b1, 1'b0);
                end
                4:
                begin
                    build_media();
                    repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom));
                    emit_packet(1'b0, $urandom, 1'b1, 1'b1, 1'b0);
                end
                5:
                begin
                    build_media();
                    emit_packet(1'b0, $urandom, 1'b1, 1'b0, 1'b0);
                end
                6:
                begin
                    build_media();
                    emit_packet(1'b0, $urandom, 1'b0, 1'b1, 1'b0);
                end
                7:
                begin
                    build_media();
                    emit_packet(1'b0, $urandom, 1'b1, 1'b1, 1'b1);
                end
                default:
                begin
                    build_media();
                    emit_packet(1'b0, $urandom, 1'b1, 1'b1, 1'b0);
                end
            endcase
            idx++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending.size() != 0 || pkt_bus.valid || annexb_expected.size() != 0);
        repeat (16) @(posedge clk);
        if (faults == 0 && annexb_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/favc_pkg.sv
rtl/core/favc_pkt_if.sv
rtl/core/favc_nal_if.sv
rtl/core/favc_front.sv
rtl/core/favc_queue.sv
rtl/core/favc_back.sv
rtl/core/flv_avc_length_to_annexb_top.sv
test/tb.sv
